// ===== hdl/cpvpi_pkg.sv =====
package cpvpi_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int GAIN_W     = 20;
    localparam int FRAC_W     = 16;
    localparam int LIMIT_W    = 31;
    localparam int INTEG_W    = 48;

    // shared multiplier: signed A by unsigned-as-signed B
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    // split point for operands wider than the multiplier
    localparam int SPLIT_W = 24;
    localparam int X_W     = 53;
    localparam int P_W     = 36;
    localparam int ACC_W   = 72;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_PROP_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_INT_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SUPPLY    = 3'd5;

    localparam logic [GAIN_W-1:0]  RST_POS_GAIN      = 20'd131072;
    localparam logic [GAIN_W-1:0]  RST_VEL_PROP_GAIN = 20'd1966;
    localparam logic [GAIN_W-1:0]  RST_VEL_INT_GAIN  = 20'd37880;
    localparam logic [FRAC_W-1:0]  RST_HALF_PERIOD   = 16'd328;
    localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT   = 31'd26214400;
    localparam logic [FRAC_W-1:0]  RST_INV_SUPPLY    = 16'd7992;

    localparam logic ACT_POSITION = 1'b0;
    localparam logic ACT_VELOCITY = 1'b1;

    localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic [DATA_W-1:0]  DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0]  DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] measurement;
        logic [DATA_W-1:0] target_angle;
    } in_word_t;

    typedef struct packed {
        logic              tick_kind;
        logic [DATA_W-1:0] speed_command;
        logic [DATA_W-1:0] duty;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_MUL,
        ST_POS_CLIP,
        ST_VEL_SUM,
        ST_VEL_INC_MUL,
        ST_VEL_INT_ADD,
        ST_VEL_P,
        ST_VEL_I_LO,
        ST_VEL_I_HI,
        ST_VEL_PI,
        ST_VEL_D_LO,
        ST_VEL_D_HI,
        ST_VEL_D_ACC,
        ST_VEL_SAT,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/cascaded_position_velocity_pi_top.sv =====
// Cascaded position P / velocity PI controller. One word in gives one word out.
// The input is stalled from accept until the result is loaded into the output
// register, so no new word is taken while a tick is in progress; the next tick
// is taken while that result still waits. The length of each tick is set by a
// single 34x21 multiplier that serves every product in turn: the 48-bit
// integral product and the 53-bit drive product go through it in two halves,
// with each product registered before the following add.
// All internal fractions round to nearest, ties up; the integrator saturates
// at 48 bits and the duty at 32 bits. Registers written between ticks take
// effect on the next tick; the user must keep writes between ticks, which the
// block itself does not enforce.
module cascaded_position_velocity_pi_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  cpvpi_pkg::in_word_t           in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output cpvpi_pkg::out_word_t          out_data,
    input  logic                          cfg_write,
    input  logic [cpvpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpvpi_pkg::CFG_DATA_W-1:0] cfg_data
);

    cpvpi_pkg::state_t state_reg, state_next;

    // configuration
    logic [cpvpi_pkg::GAIN_W-1:0]  pos_gain_reg, pos_gain_next;
    logic [cpvpi_pkg::GAIN_W-1:0]  vel_prop_gain_reg, vel_prop_gain_next;
    logic [cpvpi_pkg::GAIN_W-1:0]  vel_int_gain_reg, vel_int_gain_next;
    logic [cpvpi_pkg::FRAC_W-1:0]  half_period_reg, half_period_next;
    logic [cpvpi_pkg::LIMIT_W-1:0] speed_limit_reg, speed_limit_next;
    logic [cpvpi_pkg::FRAC_W-1:0]  inv_supply_reg, inv_supply_next;

    // controller state
    logic signed [cpvpi_pkg::DATA_W-1:0]  setpoint_reg, setpoint_next;
    logic signed [cpvpi_pkg::INTEG_W-1:0] integ_reg, integ_next;
    logic signed [cpvpi_pkg::DATA_W-1:0]  last_err_reg, last_err_next;
    logic signed [cpvpi_pkg::DATA_W-1:0]  last_duty_reg, last_duty_next;
    logic                                 out_valid_reg, out_valid_next;

    // working registers
    logic                                 kind_reg, kind_next;
    logic signed [cpvpi_pkg::DATA_W-1:0]  e_reg, e_next;
    logic signed [cpvpi_pkg::X_W-1:0]     x_reg, x_next;
    logic signed [cpvpi_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [cpvpi_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [cpvpi_pkg::P_W-1:0]     p_reg, p_next;
    cpvpi_pkg::out_word_t                 out_data_reg, out_data_next;

    logic signed [cpvpi_pkg::MUL_A_W-1:0] mul_a;
    logic signed [cpvpi_pkg::MUL_B_W-1:0] mul_b;

    logic accept;
    logic out_load;

    logic signed [32:0] diff_pos;
    logic signed [32:0] diff_vel;
    logic signed [32:0] err_sum;
    logic signed [cpvpi_pkg::PROD_W-1:0] prod_rnd;
    logic signed [38:0] pos_rnd;
    logic signed [38:0] lim_pos;
    logic signed [38:0] lim_neg;
    logic signed [65:0] int_sum;
    logic signed [49:0] int_val;
    logic signed [cpvpi_pkg::ACC_W-1:0] pi_sum;
    logic signed [cpvpi_pkg::ACC_W-1:0] duty_full;
    logic signed [55:0] duty_val;
    logic signed [cpvpi_pkg::ACC_W-1:0] prod_hi;

    assign in_stall  = (state_reg != cpvpi_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_load  = (state_reg == cpvpi_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpvpi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_data.action == cpvpi_pkg::ACT_VELOCITY)
                                 ? cpvpi_pkg::ST_VEL_SUM : cpvpi_pkg::ST_POS_MUL;
                end
            end
            cpvpi_pkg::ST_POS_MUL:     state_next = cpvpi_pkg::ST_POS_CLIP;
            cpvpi_pkg::ST_POS_CLIP:    state_next = cpvpi_pkg::ST_DONE;
            cpvpi_pkg::ST_VEL_SUM:     state_next = cpvpi_pkg::ST_VEL_INC_MUL;
            cpvpi_pkg::ST_VEL_INC_MUL: state_next = cpvpi_pkg::ST_VEL_INT_ADD;
            cpvpi_pkg::ST_VEL_INT_ADD: state_next = cpvpi_pkg::ST_VEL_P;
            cpvpi_pkg::ST_VEL_P:       state_next = cpvpi_pkg::ST_VEL_I_LO;
            cpvpi_pkg::ST_VEL_I_LO:    state_next = cpvpi_pkg::ST_VEL_I_HI;
            cpvpi_pkg::ST_VEL_I_HI:    state_next = cpvpi_pkg::ST_VEL_PI;
            cpvpi_pkg::ST_VEL_PI:      state_next = cpvpi_pkg::ST_VEL_D_LO;
            cpvpi_pkg::ST_VEL_D_LO:    state_next = cpvpi_pkg::ST_VEL_D_HI;
            cpvpi_pkg::ST_VEL_D_HI:    state_next = cpvpi_pkg::ST_VEL_D_ACC;
            cpvpi_pkg::ST_VEL_D_ACC:   state_next = cpvpi_pkg::ST_VEL_SAT;
            cpvpi_pkg::ST_VEL_SAT:     state_next = cpvpi_pkg::ST_DONE;
            cpvpi_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = cpvpi_pkg::ST_IDLE;
                end
            end
            default:                   state_next = cpvpi_pkg::ST_IDLE;
        endcase
    end

    // multiplier operand select; wide operands go low half (unsigned) then high half
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            cpvpi_pkg::ST_POS_MUL:
            begin
                mul_a = x_reg[cpvpi_pkg::MUL_A_W-1:0];
                mul_b = $signed({1'b0, pos_gain_reg});
            end
            cpvpi_pkg::ST_VEL_INC_MUL:
            begin
                mul_a = x_reg[cpvpi_pkg::MUL_A_W-1:0];
                mul_b = $signed({5'b0, half_period_reg});
            end
            cpvpi_pkg::ST_VEL_INT_ADD:
            begin
                mul_a = $signed({{2{e_reg[31]}}, e_reg});
                mul_b = $signed({1'b0, vel_prop_gain_reg});
            end
            cpvpi_pkg::ST_VEL_P:
            begin
                mul_a = $signed({10'b0, integ_reg[cpvpi_pkg::SPLIT_W-1:0]});
                mul_b = $signed({1'b0, vel_int_gain_reg});
            end
            cpvpi_pkg::ST_VEL_I_LO:
            begin
                mul_a = $signed({{10{integ_reg[47]}}, integ_reg[47:cpvpi_pkg::SPLIT_W]});
                mul_b = $signed({1'b0, vel_int_gain_reg});
            end
            cpvpi_pkg::ST_VEL_D_LO:
            begin
                mul_a = $signed({10'b0, x_reg[cpvpi_pkg::SPLIT_W-1:0]});
                mul_b = $signed({5'b0, inv_supply_reg});
            end
            cpvpi_pkg::ST_VEL_D_HI:
            begin
                mul_a = $signed({{5{x_reg[52]}}, x_reg[52:cpvpi_pkg::SPLIT_W]});
                mul_b = $signed({5'b0, inv_supply_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // arithmetic around the multiplier
    assign diff_pos = $signed({in_data.target_angle[31], in_data.target_angle})
                    - $signed({in_data.measurement[31], in_data.measurement});
    assign diff_vel = $signed({setpoint_reg[31], setpoint_reg})
                    - $signed({in_data.measurement[31], in_data.measurement});
    assign err_sum  = $signed({e_reg[31], e_reg}) + $signed({last_err_reg[31], last_err_reg});
    assign prod_rnd = prod_reg + 55'sd32768;
    assign pos_rnd  = prod_rnd[54:16];
    assign lim_pos  = $signed({8'b0, speed_limit_reg});
    assign lim_neg  = -lim_pos;
    // integ + rnd(prod) folded into one three-input add
    assign int_sum  = $signed({{2{integ_reg[47]}}, integ_reg, 16'b0})
                    + $signed({{11{prod_reg[54]}}, prod_reg}) + 66'sd32768;
    assign int_val  = int_sum[65:16];
    assign pi_sum   = $signed({{20{p_reg[35]}}, p_reg, 16'b0}) + acc_reg + 72'sd32768;
    assign duty_full = acc_reg + 72'sd32768;
    assign duty_val = duty_full[71:16];
    assign prod_hi  = $signed({prod_reg[47:0], 24'b0});

    always_comb
    begin
        pos_gain_next      = pos_gain_reg;
        vel_prop_gain_next = vel_prop_gain_reg;
        vel_int_gain_next  = vel_int_gain_reg;
        half_period_next   = half_period_reg;
        speed_limit_next   = speed_limit_reg;
        inv_supply_next    = inv_supply_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                cpvpi_pkg::REG_POS_GAIN:      pos_gain_next      = cfg_data[19:0];
                cpvpi_pkg::REG_VEL_PROP_GAIN: vel_prop_gain_next = cfg_data[19:0];
                cpvpi_pkg::REG_VEL_INT_GAIN:  vel_int_gain_next  = cfg_data[19:0];
                cpvpi_pkg::REG_HALF_PERIOD:   half_period_next   = cfg_data[15:0];
                cpvpi_pkg::REG_SPEED_LIMIT:   speed_limit_next   = cfg_data;
                cpvpi_pkg::REG_INV_SUPPLY:    inv_supply_next    = cfg_data[15:0];
                default:                      pos_gain_next      = pos_gain_reg;
            endcase
        end
    end

    always_comb
    begin
        kind_next      = kind_reg;
        e_next         = e_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        setpoint_next  = setpoint_reg;
        integ_next     = integ_reg;
        last_err_next  = last_err_reg;
        last_duty_next = last_duty_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_load || (out_valid_reg && out_stall);

        unique case (state_reg)
            cpvpi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = in_data.action;
                    x_next    = {{20{diff_pos[32]}}, diff_pos};
                    // speed error saturates to 32 bits
                    if (diff_vel[32] != diff_vel[31])
                    begin
                        e_next = diff_vel[32] ? cpvpi_pkg::DATA_MIN : cpvpi_pkg::DATA_MAX;
                    end
                    else
                    begin
                        e_next = diff_vel[31:0];
                    end
                end
            end
            cpvpi_pkg::ST_POS_CLIP:
            begin
                if (pos_rnd > lim_pos)
                begin
                    setpoint_next = lim_pos[31:0];
                end
                else if (pos_rnd < lim_neg)
                begin
                    setpoint_next = lim_neg[31:0];
                end
                else
                begin
                    setpoint_next = pos_rnd[31:0];
                end
            end
            cpvpi_pkg::ST_VEL_SUM:
            begin
                x_next = {{20{err_sum[32]}}, err_sum};
            end
            cpvpi_pkg::ST_VEL_INT_ADD:
            begin
                if (int_val[49:47] == 3'b000 || int_val[49:47] == 3'b111)
                begin
                    integ_next = int_val[47:0];
                end
                else
                begin
                    integ_next = int_val[49] ? cpvpi_pkg::INTEG_MIN : cpvpi_pkg::INTEG_MAX;
                end
            end
            cpvpi_pkg::ST_VEL_P:
            begin
                p_next = prod_rnd[51:16];
            end
            cpvpi_pkg::ST_VEL_I_LO, cpvpi_pkg::ST_VEL_D_HI:
            begin
                acc_next = {{17{prod_reg[54]}}, prod_reg};
            end
            cpvpi_pkg::ST_VEL_I_HI, cpvpi_pkg::ST_VEL_D_ACC:
            begin
                acc_next = acc_reg + prod_hi;
            end
            cpvpi_pkg::ST_VEL_PI:
            begin
                x_next = pi_sum[68:16];
            end
            cpvpi_pkg::ST_VEL_SAT:
            begin
                if (&duty_val[55:31] || ~|duty_val[55:31])
                begin
                    last_duty_next = duty_val[31:0];
                end
                else
                begin
                    last_duty_next = duty_val[55] ? cpvpi_pkg::DATA_MIN : cpvpi_pkg::DATA_MAX;
                end
                last_err_next = e_reg;
            end
            cpvpi_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_data_next.tick_kind     = kind_reg;
                    out_data_next.speed_command = setpoint_reg;
                    out_data_next.duty          = last_duty_reg;
                end
            end
            default:
            begin
                kind_next = kind_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= cpvpi_pkg::ST_IDLE;
            out_valid_reg     <= 1'b0;
            pos_gain_reg      <= cpvpi_pkg::RST_POS_GAIN;
            vel_prop_gain_reg <= cpvpi_pkg::RST_VEL_PROP_GAIN;
            vel_int_gain_reg  <= cpvpi_pkg::RST_VEL_INT_GAIN;
            half_period_reg   <= cpvpi_pkg::RST_HALF_PERIOD;
            speed_limit_reg   <= cpvpi_pkg::RST_SPEED_LIMIT;
            inv_supply_reg    <= cpvpi_pkg::RST_INV_SUPPLY;
            setpoint_reg      <= '0;
            integ_reg         <= '0;
            last_err_reg      <= '0;
            last_duty_reg     <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            pos_gain_reg      <= pos_gain_next;
            vel_prop_gain_reg <= vel_prop_gain_next;
            vel_int_gain_reg  <= vel_int_gain_next;
            half_period_reg   <= half_period_next;
            speed_limit_reg   <= speed_limit_next;
            inv_supply_reg    <= inv_supply_next;
            setpoint_reg      <= setpoint_next;
            integ_reg         <= integ_next;
            last_err_reg      <= last_err_next;
            last_duty_reg     <= last_duty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        e_reg        <= e_next;
        x_reg        <= x_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        p_reg        <= p_next;
        out_data_reg <= out_data_next;
    end

    // clipped command stays inside the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpvpi_pkg::ST_POS_CLIP) |=>
            ($signed({setpoint_reg[31], setpoint_reg}) <= $signed({2'b0, speed_limit_reg}) &&
             $signed({setpoint_reg[31], setpoint_reg}) >= -$signed({2'b0, speed_limit_reg})))
        else $error("speed command outside limit");

    // a word is only loaded from the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == cpvpi_pkg::ST_DONE))
        else $error("output loaded outside final state");

    // a finished result waits while the output is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpvpi_pkg::ST_DONE && out_valid_reg && out_stall) |=>
            (state_reg == cpvpi_pkg::ST_DONE))
        else $error("result dropped while output stalled");

    // an accepted word starts a sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == cpvpi_pkg::ST_POS_MUL || state_reg == cpvpi_pkg::ST_VEL_SUM))
        else $error("accepted word did not start");

endmodule
